// ===== design/bucket_max_priority_queue_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BUCKET_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BUCKET_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
// An implication that must hold at every clock edge outside reset.
`define BMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// An implication whose consequent is checked in the cycle after its antecedent.
`define BMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/bmpq_pkg.sv =====
`default_nettype none
package bmpq_pkg;
  typedef enum logic [2:0] {
    KIND_INSERT  = 3'd0,
    KIND_UPDATE  = 3'd1,
    KIND_REMOVE  = 3'd2,
    KIND_EXTRACT = 3'd3,
    KIND_PEEK    = 3'd4,
    KIND_CLEAR   = 3'd5
  } kind_e;

  localparam int unsigned FieldW = 10;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;
endpackage
`default_nettype wire

// ===== design/bucket_max_priority_queue_core.sv =====
// Bucket max-priority queue core; one operation is in flight at a time.
// Extract and peek search down from the top pointer, skipping empty buckets; clear
// empties every bucket up to the top pointer; unused kinds, and out-of-range ids for
// insert, update and remove, go straight to a not-found result. The next input beat is
// taken no earlier than the cycle after the result beat. After reset (async, active low)
// a clearing pass marks every bucket empty and no beat is accepted until it ends.
`default_nettype none
module bucket_max_priority_queue_core #(
  parameter int unsigned NUM_ENTRIES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata fields from bit 0: item_id[9:0], item_key[19:10], zero[23:20].
  input  wire logic [23:0] s_axis_tdata,
  // tuser fields: kind[2:0].
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata fields from bit 0: found[0], out_id[10:1], out_key[20:11], zero[23:21].
  output logic [23:0]      m_axis_tdata
);
  // Links are NUM_ENTRIES+1 wide in value: NIL equals NUM_ENTRIES.
  localparam int unsigned AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned LW = $clog2(NUM_ENTRIES + 1);
  localparam logic [LW-1:0] Nil = LW'(NUM_ENTRIES);
  localparam logic [AW-1:0] MaxKey = AW'(NUM_ENTRIES - 1);

  // All link and key memories share one sequencer. Each state issues at most
  // one read per memory (data registered next cycle) and writes on the following states.
  typedef enum logic [15:0] {
    ST_INIT   = 16'h0001,
    ST_IDLE   = 16'h0002,
    ST_URD    = 16'h0004,
    ST_UWAIT  = 16'h0008,
    ST_UHEAD  = 16'h0010,
    ST_UFIX   = 16'h0020,
    ST_PRD    = 16'h0040,
    ST_PWAIT  = 16'h0080,
    ST_PFIX   = 16'h0100,
    ST_SRCH   = 16'h0200,
    ST_SWAIT  = 16'h0400,
    ST_HRD    = 16'h0800,
    ST_HWAIT  = 16'h1000,
    ST_CLR    = 16'h2000,
    ST_OUT    = 16'h4000,
    ST_FIN    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // Memories: bucket heads, per-id links and keys.
  logic [LW-1:0] head_mem [NUM_ENTRIES];
  logic [LW-1:0] prev_mem [NUM_ENTRIES];
  logic [LW-1:0] next_mem [NUM_ENTRIES];
  logic [AW-1:0] key_mem  [NUM_ENTRIES];

  logic          head_we, prev_we, next_we, key_we;
  logic [AW-1:0] head_wa, prev_wa, next_wa, key_wa, head_ra, id_ra;
  logic [LW-1:0] head_wd, prev_wd, next_wd;
  logic [AW-1:0] key_wd;
  logic [LW-1:0] head_rd_q, prev_rd_q, next_rd_q;
  logic [AW-1:0] key_rd_q;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    head_rd_q <= head_mem[head_ra];
    prev_rd_q <= prev_mem[id_ra];
    next_rd_q <= next_mem[id_ra];
    key_rd_q  <= key_mem[id_ra];
  end

  // Operation registers.
  logic [2:0]    kind_q, kind_d;
  logic [AW-1:0] id_q, id_d;
  logic [AW-1:0] key_q, key_d;
  logic [LW-1:0] p_q, p_d, nx_q, nx_d;
  // top_q holds at least top_bucket + 1, so zero means the queue is empty.
  logic [LW-1:0] top_q, top_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          found_q, found_d;
  logic [AW-1:0] oid_q, oid_d, okey_q, okey_d;
  logic          ovalid_q, ovalid_d;
  logic [AW-1:0] top_idx;

  logic [2:0]    in_kind;
  logic [9:0]    in_id, in_key;
  logic          in_id_ok;
  logic [AW-1:0] key_sat;

  assign in_kind  = s_axis_tuser;
  assign in_id    = s_axis_tdata[9:0];
  assign in_key   = s_axis_tdata[19:10];
  assign in_id_ok = 32'(in_id) < NUM_ENTRIES;
  assign key_sat  = (32'(in_key) >= NUM_ENTRIES) ? MaxKey : AW'(in_key);
  assign top_idx  = AW'(top_q - LW'(1));

  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, 10'(okey_q), 10'(oid_q), found_q};

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    id_d     = id_q;
    key_d    = key_q;
    p_d      = p_q;
    nx_d     = nx_q;
    top_d    = top_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    oid_d    = oid_q;
    okey_d   = okey_q;
    ovalid_d = ovalid_q;
    head_we = 1'b0; prev_we = 1'b0; next_we = 1'b0; key_we = 1'b0;
    head_wa = '0; prev_wa = '0; next_wa = '0; key_wa = '0;
    head_wd = Nil; prev_wd = Nil; next_wd = Nil; key_wd = '0;
    head_ra = key_q;
    id_ra   = id_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        head_we = 1'b1;
        head_wa = AW'(cnt_q);
        cnt_d   = cnt_q + LW'(1);
        if (cnt_q == LW'(NUM_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          kind_d  = in_kind;
          id_d    = AW'(in_id);
          key_d   = key_sat;
          found_d = 1'b0;
          oid_d   = '0;
          okey_d  = '0;
          cnt_d   = '0;
          case (in_kind)
            bmpq_pkg::KIND_INSERT:  state_d = in_id_ok ? ST_PRD : ST_OUT;
            bmpq_pkg::KIND_UPDATE,
            bmpq_pkg::KIND_REMOVE:  state_d = in_id_ok ? ST_URD : ST_OUT;
            bmpq_pkg::KIND_EXTRACT,
            bmpq_pkg::KIND_PEEK:    state_d = ST_SRCH;
            bmpq_pkg::KIND_CLEAR:   state_d = ST_CLR;
            default:                state_d = ST_OUT;
          endcase
        end
      end
      // Unlink: read prev, next and key of the id.
      ST_URD: begin
        state_d = ST_UWAIT;
      end
      ST_UWAIT: begin
        p_d  = prev_rd_q;
        nx_d = next_rd_q;
        if (prev_rd_q == Nil) begin
          head_we = 1'b1;
          head_wa = key_rd_q;
          head_wd = next_rd_q;
        end else begin
          next_we = 1'b1;
          next_wa = AW'(prev_rd_q);
          next_wd = next_rd_q;
        end
        state_d = ST_UFIX;
      end
      ST_UFIX: begin
        if (nx_q != Nil) begin
          prev_we = 1'b1;
          prev_wa = AW'(nx_q);
          prev_wd = p_q;
        end
        state_d = (kind_q == bmpq_pkg::KIND_UPDATE) ? ST_UHEAD : ST_OUT;
      end
      // Head of the target bucket is read after the unlink has written.
      ST_UHEAD: begin
        state_d = ST_PRD;
      end
      // Push: read the bucket head.
      ST_PRD: begin
        state_d = ST_PWAIT;
      end
      ST_PWAIT: begin
        nx_d    = head_rd_q;
        key_we  = 1'b1;
        key_wa  = id_q;
        key_wd  = key_q;
        prev_we = 1'b1;
        prev_wa = id_q;
        prev_wd = Nil;
        next_we = 1'b1;
        next_wa = id_q;
        next_wd = head_rd_q;
        head_we = 1'b1;
        head_wa = key_q;
        head_wd = LW'(id_q);
        if ((LW'(key_q) + LW'(1)) > top_q) begin
          top_d = LW'(key_q) + LW'(1);
        end
        state_d = ST_PFIX;
      end
      // The old head gets the pushed id as its predecessor; after a pop it
      // becomes the new head and has none.
      ST_PFIX: begin
        if (nx_q != Nil) begin
          prev_we = 1'b1;
          prev_wa = AW'(nx_q);
          prev_wd = (kind_q == bmpq_pkg::KIND_EXTRACT) ? Nil : LW'(id_q);
        end
        state_d = ST_OUT;
      end
      // Top search: read the head at the top pointer and step down past empty buckets.
      ST_SRCH: begin
        head_ra = top_idx;
        state_d = (top_q == '0) ? ST_OUT : ST_SWAIT;
      end
      ST_SWAIT: begin
        if (head_rd_q == Nil) begin
          top_d   = top_q - LW'(1);
          state_d = ST_SRCH;
        end else begin
          id_d    = AW'(head_rd_q);
          state_d = ST_HRD;
        end
      end
      ST_HRD: begin
        state_d = ST_HWAIT;
      end
      ST_HWAIT: begin
        found_d = 1'b1;
        oid_d   = id_q;
        okey_d  = key_rd_q;
        nx_d    = next_rd_q;
        if (kind_q == bmpq_pkg::KIND_EXTRACT) begin
          head_we = 1'b1;
          head_wa = top_idx;
          head_wd = next_rd_q;
          state_d = ST_PFIX;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_CLR: begin
        if (cnt_q < top_q) begin
          head_we = 1'b1;
          head_wa = AW'(cnt_q);
          cnt_d   = cnt_q + LW'(1);
        end else begin
          top_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        ovalid_d = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cnt_q    <= '0;
      top_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      top_q    <= top_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    id_q    <= id_d;
    key_q   <= key_d;
    p_q     <= p_d;
    nx_q    <= nx_d;
    found_q <= found_d;
    oid_q   <= oid_d;
    okey_q  <= okey_d;
  end
endmodule
`default_nettype wire

// ===== design/bmpq_checker.sv =====
`default_nettype none
`include "bucket_max_priority_queue_core_defines.svh"
module bmpq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  // A result waiting blocks new input.
  `BMPQ_ASSERT_IMPL(a_no_accept_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "input accepted while result pending")
  // An accepted beat never shows its result in the next cycle.
  `BMPQ_ASSERT_NEXT(a_no_instant, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
  // A result without found carries zero id and key.
  `BMPQ_ASSERT_IMPL(a_zero_fields, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[23:1] == 23'd0, "nonzero fields without found")
  // A stalled result holds.
  `BMPQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
endmodule
bind bucket_max_priority_queue_core bmpq_checker u_bmpq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== tb/bucket_max_priority_queue_core_test.sv =====
`timescale 1ns / 1ps
module bucket_max_priority_queue_core_test;

  localparam int unsigned Slots = 1024;
  localparam logic [10:0] EmptyMark = 11'd1024;
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] id;
    logic [9:0] key;
  } op_t;

  typedef struct packed {
    logic       found;
    logic [9:0] id;
    logic [9:0] key;
  } answer_t;

  // Mirror of the queue plus the answers still owed by the block.
  class queue_scoreboard;
    logic [10:0] bucket_top_id[Slots];
    logic [10:0] link_up[Slots];
    logic [10:0] link_down[Slots];
    logic [9:0]  stored_key[Slots];
    int          top_key;
    bit          enqueued[Slots];
    int          members[$];
    answer_t     owed[$];
    int          errors;

    function new();
      for (int i = 0; i < Slots; i++) begin
        bucket_top_id[i] = EmptyMark;
        link_up[i] = '0;
        link_down[i] = '0;
        stored_key[i] = '0;
        enqueued[i] = 1'b0;
      end
      top_key = -1;
      errors = 0;
    endfunction

    function void drop_member(int id);
      enqueued[id] = 1'b0;
      foreach (members[i]) begin
        if (members[i] == id) begin
          members.delete(i);
          break;
        end
      end
    endfunction

    function void push(int id, logic [9:0] key);
      logic [10:0] old;
      old = bucket_top_id[key];
      stored_key[id] = key;
      link_up[id] = EmptyMark;
      link_down[id] = old;
      if (old != EmptyMark) link_up[old[9:0]] = id[10:0];
      bucket_top_id[key] = id[10:0];
      if (int'(key) > top_key) top_key = key;
      enqueued[id] = 1'b1;
      members.push_back(id);
    endfunction

    function void unlink(int id);
      logic [10:0] up;
      logic [10:0] down;
      up = link_up[id];
      down = link_down[id];
      if (up == EmptyMark) begin
        bucket_top_id[stored_key[id]] = down;
        if (down != EmptyMark) link_up[down[9:0]] = EmptyMark;
      end else begin
        link_down[up[9:0]] = down;
        if (down != EmptyMark) link_up[down[9:0]] = up;
      end
      drop_member(id);
    endfunction

    // Applies one accepted operation and queues the answer it must produce.
    function void note_op(op_t op);
      answer_t ans;
      logic [10:0] h;
      ans = '0;
      case (op.kind)
        bmpq_pkg::KIND_INSERT: push(op.id, op.key);
        bmpq_pkg::KIND_UPDATE: begin
          unlink(op.id);
          push(op.id, op.key);
        end
        bmpq_pkg::KIND_REMOVE: unlink(op.id);
        bmpq_pkg::KIND_EXTRACT, bmpq_pkg::KIND_PEEK: begin
          while (top_key >= 0 && bucket_top_id[top_key] == EmptyMark) top_key--;
          if (top_key >= 0) begin
            h = bucket_top_id[top_key];
            ans.found = 1'b1;
            ans.id = h[9:0];
            ans.key = stored_key[h[9:0]];
            if (op.kind == bmpq_pkg::KIND_EXTRACT) begin
              bucket_top_id[top_key] = link_down[h[9:0]];
              if (link_down[h[9:0]] != EmptyMark) link_up[link_down[h[9:0]][9:0]] = EmptyMark;
              drop_member(h[9:0]);
            end
          end
        end
        bmpq_pkg::KIND_CLEAR: begin
          for (int i = 0; i <= top_key; i++) bucket_top_id[i] = EmptyMark;
          top_key = -1;
          foreach (members[i]) enqueued[members[i]] = 1'b0;
          members.delete();
        end
        default: ;
      endcase
      owed.push_back(ans);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_answer(logic [23:0] data);
      answer_t got;
      answer_t want;
      got.found = data[0];
      got.id = data[10:1];
      got.key = data[20:11];
      if (owed.size() == 0) begin
        report($sformatf("unexpected result beat %h", data));
      end else begin
        want = owed.pop_front();
        if (got.found !== want.found)
          report($sformatf("found %b, wanted %b", got.found, want.found));
        if (got.id !== want.id)
          report($sformatf("out_id %0d, wanted %0d", got.id, want.id));
        if (got.key !== want.key)
          report($sformatf("out_key %0d, wanted %0d", got.key, want.key));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  queue_scoreboard sb = new();
  int  accepted = 0;
  int  gap_left = 0;

  bucket_max_priority_queue_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offers one beat at the falling edge and holds it until the block takes it.
  // Between beats the sender may go quiet for a random gap.
  task send_op(op_t op);
    if (gap_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
    if (gap_left > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap_left - 1) @(negedge clk_i);
      gap_left = 0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op.kind;
    s_axis_tdata <= {4'b0, op.key, op.id};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(op);
    accepted++;
  endtask

  task send(logic [2:0] kind, logic [9:0] id, logic [9:0] key);
    op_t op;
    op.kind = kind;
    op.id = id;
    op.key = key;
    send_op(op);
  endtask

  // Builds a legal random operation: ids are inserted only when absent and
  // removed or moved only when present.
  function op_t random_op();
    op_t op;
    int pick;
    op.id = 10'($urandom);
    op.key = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 38) op.kind = bmpq_pkg::KIND_INSERT;
    else if (pick < 52) op.kind = bmpq_pkg::KIND_UPDATE;
    else if (pick < 66) op.kind = bmpq_pkg::KIND_REMOVE;
    else if (pick < 82) op.kind = bmpq_pkg::KIND_EXTRACT;
    else if (pick < 95) op.kind = bmpq_pkg::KIND_PEEK;
    else if (pick < 97) op.kind = bmpq_pkg::KIND_CLEAR;
    else op.kind = pick[0] ? KIND_SPARE_LO : KIND_SPARE_HI;
    if (op.kind == bmpq_pkg::KIND_UPDATE || op.kind == bmpq_pkg::KIND_REMOVE) begin
      if (sb.members.size() == 0) op.kind = bmpq_pkg::KIND_INSERT;
      else op.id = 10'(sb.members[$urandom_range(0, sb.members.size() - 1)]);
    end
    if (op.kind == bmpq_pkg::KIND_INSERT) begin
      while (sb.enqueued[op.id]) op.id = 10'($urandom);
    end
    return op;
  endfunction

  // Receiver: random stalls, calm stretches, and one long hold-off that lets
  // the block back up into its input.
  initial begin
    bit held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && accepted >= 120) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else if ((accepted / 60) % 2 == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_answer(m_axis_tdata);
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue first, then extremes, ordering within one bucket and spare kinds.
    send(bmpq_pkg::KIND_PEEK, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_EXTRACT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_INSERT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_INSERT, 10'd1023, 10'd1023);
    send(bmpq_pkg::KIND_INSERT, 10'd5, 10'd1023);
    send(bmpq_pkg::KIND_PEEK, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_EXTRACT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_UPDATE, 10'd0, 10'd512);
    send(bmpq_pkg::KIND_EXTRACT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_INSERT, 10'd682, 10'd341);
    send(bmpq_pkg::KIND_INSERT, 10'd341, 10'd341);
    send(bmpq_pkg::KIND_REMOVE, 10'd682, 10'd0);
    send(KIND_SPARE_LO, 10'd1023, 10'd1023);
    send(KIND_SPARE_HI, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_EXTRACT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_EXTRACT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_EXTRACT, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_INSERT, 10'd7, 10'd900);
    send(bmpq_pkg::KIND_CLEAR, 10'd0, 10'd0);
    send(bmpq_pkg::KIND_PEEK, 10'd0, 10'd0);

    for (int n = 0; n < 500; n++) send_op(random_op());

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/bmpq_pkg.sv
design/bucket_max_priority_queue_core.sv
design/bmpq_checker.sv
tb/bucket_max_priority_queue_core_test.sv
